/* src/lvw_pkg.sv */
// Shared constants and types for the 3D voxel line walker.
`timescale 1ns / 1ps

package lvw_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_OFFSET_DEF = 63;

    localparam int AXES      = 3;
    localparam int FIELD_W   = 16;
    localparam int OFF_W     = 7;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 48;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Direction and driving-axis selection for one line.
    typedef struct packed {
        logic [AXES-1:0] neg;
        logic [1:0]      maj;
    } lvw_ctrl_t;

endpackage

/* src/lvw_setup.sv */
// Line setup: offset clamp, magnitudes, driving axis and initial error terms.
`timescale 1ns / 1ps

module lvw_setup #(
    parameter int MAX_OFFSET = lvw_pkg::MAX_OFFSET_DEF,
    parameter int OFF_BITS   = $clog2(MAX_OFFSET + 1),
    parameter int ERR_W      = OFF_BITS + 3
) (
    input  logic [lvw_pkg::OFF_W-1:0]    offset [lvw_pkg::AXES],
    output logic [OFF_BITS-1:0]          mag    [lvw_pkg::AXES],
    output logic signed [ERR_W-1:0]      err    [lvw_pkg::AXES],
    output logic [OFF_BITS-1:0]          len,
    output lvw_pkg::lvw_ctrl_t           ctrl
);

    localparam int OW = lvw_pkg::OFF_W;

    logic [OW-1:0] abs_off [lvw_pkg::AXES];

    always_comb begin
        for (int i = 0; i < lvw_pkg::AXES; i++) begin
            ctrl.neg[i] = offset[i][OW-1];
            abs_off[i]  = offset[i][OW-1] ? OW'(-offset[i]) : offset[i];
            // saturate out-of-range offsets, the most negative code included
            if (abs_off[i] > OW'(MAX_OFFSET)) begin
                mag[i] = OFF_BITS'(MAX_OFFSET);
            end else begin
                mag[i] = abs_off[i][OFF_BITS-1:0];
            end
        end

        if (mag[0] > mag[1] && mag[0] > mag[2]) begin
            ctrl.maj = lvw_pkg::AXIS_X;
            len      = mag[0];
        end else if (mag[1] >= mag[0] && mag[1] >= mag[2]) begin
            ctrl.maj = lvw_pkg::AXIS_Y;
            len      = mag[1];
        end else begin
            ctrl.maj = lvw_pkg::AXIS_Z;
            len      = mag[2];
        end

        for (int i = 0; i < lvw_pkg::AXES; i++) begin
            err[i] = signed'(ERR_W'({mag[i], 1'b0})) - signed'(ERR_W'(len));
        end
    end

endmodule

/* src/lvw_step.sv */
// Shared step unit: one step; moves each axis that fires, updates all error terms.
`timescale 1ns / 1ps

module lvw_step #(
    parameter int COORD_BITS = lvw_pkg::COORD_BITS_DEF,
    parameter int OFF_BITS   = 6,
    parameter int ERR_W      = OFF_BITS + 3
) (
    input  logic [COORD_BITS-1:0]        pos      [lvw_pkg::AXES],
    input  logic signed [ERR_W-1:0]      err      [lvw_pkg::AXES],
    input  logic [OFF_BITS-1:0]          mag      [lvw_pkg::AXES],
    input  logic [OFF_BITS-1:0]          len,
    input  lvw_pkg::lvw_ctrl_t           ctrl,
    output logic [COORD_BITS-1:0]        pos_next [lvw_pkg::AXES],
    output logic signed [ERR_W-1:0]      err_next [lvw_pkg::AXES]
);

    logic signed [ERR_W-1:0] two_l;
    logic signed [ERR_W-1:0] two_d [lvw_pkg::AXES];
    logic [lvw_pkg::AXES-1:0] fire;
    logic [lvw_pkg::AXES-1:0] err_ge;

    always_comb begin
        two_l = signed'(ERR_W'({len, 1'b0}));
        for (int i = 0; i < lvw_pkg::AXES; i++) begin
            two_d[i]  = signed'(ERR_W'({mag[i], 1'b0}));
            err_ge[i] = !err[i][ERR_W-1];
            // driving axis always moves; a minor axis moves on a non-negative error
            fire[i]   = (ctrl.maj == 2'(i)) || err_ge[i];
            if (!fire[i]) begin
                pos_next[i] = pos[i];
            end else if (ctrl.neg[i]) begin
                pos_next[i] = pos[i] - COORD_BITS'(1);
            end else begin
                pos_next[i] = pos[i] + COORD_BITS'(1);
            end
            err_next[i] = (err_ge[i] ? err[i] - two_l : err[i]) + two_d[i];
        end
    end

endmodule

/* src/line_voxel_walk_3d.sv */
// Top level of the 3D voxel line walker: request handshake, sequencer, output register.
//
//   channel   dir  fields (low bit up)
//   s_axis    in   tdata: start_x, start_y, start_z, offset_x, offset_y, offset_z, 3 pad bits
//   m_axis    out  tdata: voxel_x, voxel_y, voxel_z; tlast: is_last
//
// A request is accepted in idle and set up in the setup state, then the shared step unit takes
// one step per voxel, L voxels for a driving-axis length L (0 to MAX_OFFSET).
// A zero-length request produces no output and returns from setup to idle.
// s_axis_tready is high only while the sequencer is idle; a stalled m_axis holds the walk.
// aresetn is synchronous and clears the sequencer and output valid only.
`timescale 1ns / 1ps

module line_voxel_walk_3d #(
    parameter int COORD_BITS = lvw_pkg::COORD_BITS_DEF,
    parameter int MAX_OFFSET = lvw_pkg::MAX_OFFSET_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_x[15:0], start_y[31:16], start_z[47:32],
    // offset_x[54:48], offset_y[61:55], offset_z[68:62], zero pad [71:69]
    input  logic [lvw_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // voxel_x[15:0], voxel_y[31:16], voxel_z[47:32]
    output logic [lvw_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int FW       = lvw_pkg::FIELD_W;
    localparam int OW       = lvw_pkg::OFF_W;
    localparam int AX       = lvw_pkg::AXES;
    localparam int OFF_BITS = $clog2(MAX_OFFSET + 1);
    localparam int ERR_W    = OFF_BITS + 3;
    localparam int EXT_W    = (COORD_BITS > FW) ? COORD_BITS : FW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [COORD_BITS-1:0]     pos_reg  [AX];
    logic [OW-1:0]             off_reg  [AX];
    logic signed [ERR_W-1:0]   err_reg  [AX];
    logic [OFF_BITS-1:0]       mag_reg  [AX];
    logic [OFF_BITS-1:0]       len_reg;
    logic [OFF_BITS-1:0]       cnt_reg;
    lvw_pkg::lvw_ctrl_t        ctrl_reg;
    logic                      m_valid_reg;
    logic                      m_last_reg;
    logic [FW-1:0]             m_vox_reg [AX];

    logic [OFF_BITS-1:0]       su_mag [AX];
    logic signed [ERR_W-1:0]   su_err [AX];
    logic [OFF_BITS-1:0]       su_len;
    lvw_pkg::lvw_ctrl_t        su_ctrl;
    logic [COORD_BITS-1:0]     st_pos [AX];
    logic signed [ERR_W-1:0]   st_err [AX];

    logic [FW-1:0]             in_start [AX];
    logic [OW-1:0]             in_off   [AX];
    logic                      s_fire;
    logic                      step_fire;
    logic                      last_step;

    function automatic logic [FW-1:0] coord_to_field(input logic [COORD_BITS-1:0] c);
        logic signed [EXT_W-1:0] ext;
        ext = EXT_W'(signed'(c));
        return ext[FW-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] field_to_coord(input logic [FW-1:0] f);
        logic signed [EXT_W-1:0] ext;
        ext = EXT_W'(signed'(f));
        return ext[COORD_BITS-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < AX; i++) begin
            in_start[i] = s_axis_tdata[i*FW +: FW];
            in_off[i]   = s_axis_tdata[AX*FW + i*OW +: OW];
        end
    end

    lvw_setup #(
        .MAX_OFFSET (MAX_OFFSET),
        .OFF_BITS   (OFF_BITS),
        .ERR_W      (ERR_W)
    ) u_setup (
        .offset (off_reg),
        .mag    (su_mag),
        .err    (su_err),
        .len    (su_len),
        .ctrl   (su_ctrl)
    );

    lvw_step #(
        .COORD_BITS (COORD_BITS),
        .OFF_BITS   (OFF_BITS),
        .ERR_W      (ERR_W)
    ) u_step (
        .pos      (pos_reg),
        .err      (err_reg),
        .mag      (mag_reg),
        .len      (len_reg),
        .ctrl     (ctrl_reg),
        .pos_next (st_pos),
        .err_next (st_err)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    // advance only when the output register is free or being drained
    assign step_fire     = (state_reg == ST_WALK) && (!m_valid_reg || m_axis_tready);
    assign last_step     = (cnt_reg == OFF_BITS'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = (su_len == '0) ? ST_IDLE : ST_WALK;
            end
            ST_WALK: begin
                if (step_fire && last_step) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (step_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < AX; i++) begin
                pos_reg[i] <= field_to_coord(in_start[i]);
                off_reg[i] <= in_off[i];
            end
        end else if (step_fire) begin
            for (int i = 0; i < AX; i++) begin
                pos_reg[i] <= st_pos[i];
            end
        end

        if (state_reg == ST_SETUP) begin
            for (int i = 0; i < AX; i++) begin
                err_reg[i] <= su_err[i];
                mag_reg[i] <= su_mag[i];
            end
            len_reg  <= su_len;
            cnt_reg  <= su_len;
            ctrl_reg <= su_ctrl;
        end else if (step_fire) begin
            for (int i = 0; i < AX; i++) begin
                err_reg[i] <= st_err[i];
            end
            cnt_reg <= cnt_reg - OFF_BITS'(1);
        end

        if (step_fire) begin
            for (int i = 0; i < AX; i++) begin
                m_vox_reg[i] <= coord_to_field(st_pos[i]);
            end
            m_last_reg <= last_step;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {m_vox_reg[2], m_vox_reg[1], m_vox_reg[0]};

    // the walk never runs with an exhausted step count
    a_walk_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> cnt_reg != '0)
        else $error("walk state with zero remaining steps");

    // the final step hands the block back to idle with tlast set
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && last_step) |=> state_reg == ST_IDLE && m_axis_tlast)
        else $error("final step did not end the walk");

    // setup never emits a voxel
    a_setup_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SETUP |=> !$rose(m_axis_tvalid))
        else $error("output produced during setup");

    // an accepted request moves the block to setup, with no step taken there
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_SETUP && !step_fire)
        else $error("request accepted outside idle");

endmodule

/* verif/line_voxel_walk_3d_test.sv */
// Self-checking testbench for the 3D voxel line walker: directed table, then random walks.
`timescale 1ns / 1ps

module line_voxel_walk_3d_test;

    typedef struct packed {
        logic [lvw_pkg::FIELD_W-1:0] x;
        logic [lvw_pkg::FIELD_W-1:0] y;
        logic [lvw_pkg::FIELD_W-1:0] z;
        logic                        last;
    } voxel_t;

    // One directed request; typed rows carry their own answer (none or a single end voxel).
    typedef struct packed {
        logic [lvw_pkg::FIELD_W-1:0] sx;
        logic [lvw_pkg::FIELD_W-1:0] sy;
        logic [lvw_pkg::FIELD_W-1:0] sz;
        logic [lvw_pkg::OFF_W-1:0]   ox;
        logic [lvw_pkg::OFF_W-1:0]   oy;
        logic [lvw_pkg::OFF_W-1:0]   oz;
        logic                        typed;
        logic                        one_voxel;
        logic [lvw_pkg::FIELD_W-1:0] ex;
        logic [lvw_pkg::FIELD_W-1:0] ey;
        logic [lvw_pkg::FIELD_W-1:0] ez;
    } walk_row_t;

    localparam int NUM_ROWS       = 23;
    localparam int RANDOM_WALKS   = 200;
    localparam int DRAIN_CYCLES   = lvw_pkg::MAX_OFFSET_DEF + 8;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [lvw_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [lvw_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic                           m_axis_tlast;

    voxel_t voxel_expect [$];
    int     failures = 0;
    int     voxels_checked = 0;
    int     requests_sent = 0;
    int     longest_walk = 0;
    int     burst_left = 0;

    // receiver stall pattern
    int     ready_mode = 0;
    int     mode_left = 0;
    int     hold_left = 0;
    logic   ready_next;
    voxel_t got_voxel;
    voxel_t want_voxel;

    walk_row_t walk_rows [0:NUM_ROWS-1] = '{
        // all offsets zero: nothing comes out
        '{16'h0000, 16'h0000, 16'h0000, 7'd0, 7'd0, 7'd0, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h7fff, 16'h8000, 16'h7fff, 7'd0, 7'd0, 7'd0, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0},
        // single steps, with wrap at both ends of the coordinate range
        '{16'h0000, 16'h0000, 16'h0000, 7'd1, 7'd0, 7'd0,
          1'b1, 1'b1, 16'h0001, 16'h0000, 16'h0000},
        '{16'h7fff, 16'h0000, 16'h0000, 7'd1, 7'd0, 7'd0,
          1'b1, 1'b1, 16'h8000, 16'h0000, 16'h0000},
        '{16'h0000, 16'h8000, 16'h0000, 7'h7f, 7'd0, 7'd0,
          1'b1, 1'b1, 16'hffff, 16'h8000, 16'h0000},
        '{16'h0000, 16'h8000, 16'h0000, 7'd0, 7'h7f, 7'd0,
          1'b1, 1'b1, 16'h0000, 16'h7fff, 16'h0000},
        '{16'h0000, 16'h0000, 16'h7fff, 7'd0, 7'd0, 7'd1,
          1'b1, 1'b1, 16'h0000, 16'h0000, 16'h8000},
        '{16'h0001, 16'h0001, 16'h0001, 7'h7f, 7'h7f, 7'h7f,
          1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000},
        // full-length walks along each axis
        '{16'h0000, 16'h0000, 16'h0000, 7'd63, 7'd0, 7'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0000, 16'h0000, 16'h0000, 7'h41, 7'd0, 7'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0000, 16'h0000, 16'h0000, 7'd0, 7'd63, 7'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0000, 16'h0000, 16'h0000, 7'd0, 7'd0, 7'h41, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        // most negative offset saturates; full-length diagonals
        '{16'h1234, 16'h0000, 16'h0000, 7'h40, 7'd0, 7'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0000, 16'h0000, 16'h0000, 7'h40, 7'h40, 7'h40, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0000, 16'h0000, 16'h0000, 7'd63, 7'd63, 7'd63, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0000, 16'h0000, 16'h0000, 7'd63, 7'h40, 7'd63, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        // driving-axis ties, and one walk with a lone longest X axis
        '{16'h0100, 16'h0200, 16'h0300, 7'd5, 7'd5, 7'd2, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0100, 16'h0200, 16'h0300, 7'd7, 7'd3, 7'd7, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h0100, 16'h0200, 16'h0300, 7'd9, 7'd4, 7'h7e, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        // walks that wrap the coordinates
        '{16'h8000, 16'h8000, 16'h8000, 7'h41, 7'h58, 7'h6f, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'h7fff, 16'h7fff, 16'h7fff, 7'd63, 7'd62, 7'd1, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        // a minor axis that never moves
        '{16'hffff, 16'h0000, 16'h5555, 7'd0, 7'd20, 7'h7b, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{16'haaaa, 16'h0000, 16'h0000, 7'h62, 7'd0, 7'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0}
    };

    line_voxel_walk_3d dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [lvw_pkg::S_DATA_W-1:0] pack_request(input walk_row_t r);
        return {3'b000, r.oz, r.oy, r.ox, r.sz, r.sy, r.sx};
    endfunction

    function automatic logic [lvw_pkg::FIELD_W-1:0] nudge(
        input logic [lvw_pkg::FIELD_W-1:0] c,
        input bit                          down
    );
        return down ? c - 1'b1 : c + 1'b1;
    endfunction

    // Queue up every voxel of the walk for one request; return its length.
    function automatic int plan_walk(input logic [lvw_pkg::S_DATA_W-1:0] req);
        logic [lvw_pkg::FIELD_W-1:0] pos [lvw_pkg::AXES];
        int     mag [lvw_pkg::AXES];
        bit     neg [lvw_pkg::AXES];
        int     off, maj, m1, m2, len, err1, err2;
        voxel_t v;
        for (int i = 0; i < lvw_pkg::AXES; i++) begin
            pos[i] = req[lvw_pkg::FIELD_W*i +: lvw_pkg::FIELD_W];
            off = $signed(req[lvw_pkg::AXES*lvw_pkg::FIELD_W + lvw_pkg::OFF_W*i +: lvw_pkg::OFF_W]);
            if (off < -lvw_pkg::MAX_OFFSET_DEF) off = -lvw_pkg::MAX_OFFSET_DEF;
            if (off > lvw_pkg::MAX_OFFSET_DEF) off = lvw_pkg::MAX_OFFSET_DEF;
            neg[i] = off < 0;
            mag[i] = neg[i] ? -off : off;
        end
        if (mag[lvw_pkg::AXIS_X] > mag[lvw_pkg::AXIS_Y] &&
            mag[lvw_pkg::AXIS_X] > mag[lvw_pkg::AXIS_Z]) begin
            maj = lvw_pkg::AXIS_X; m1 = lvw_pkg::AXIS_Y; m2 = lvw_pkg::AXIS_Z;
        end else if (mag[lvw_pkg::AXIS_Y] >= mag[lvw_pkg::AXIS_X] &&
                     mag[lvw_pkg::AXIS_Y] >= mag[lvw_pkg::AXIS_Z]) begin
            maj = lvw_pkg::AXIS_Y; m1 = lvw_pkg::AXIS_X; m2 = lvw_pkg::AXIS_Z;
        end else begin
            maj = lvw_pkg::AXIS_Z; m1 = lvw_pkg::AXIS_Y; m2 = lvw_pkg::AXIS_X;
        end
        len  = mag[maj];
        err1 = 2 * mag[m1] - len;
        err2 = 2 * mag[m2] - len;
        for (int k = 0; k < len; k++) begin
            pos[maj] = nudge(pos[maj], neg[maj]);
            if (err1 >= 0) begin
                pos[m1] = nudge(pos[m1], neg[m1]);
                err1 -= 2 * len;
            end
            if (err2 >= 0) begin
                pos[m2] = nudge(pos[m2], neg[m2]);
                err2 -= 2 * len;
            end
            err1 += 2 * mag[m1];
            err2 += 2 * mag[m2];
            v.x    = pos[lvw_pkg::AXIS_X];
            v.y    = pos[lvw_pkg::AXIS_Y];
            v.z    = pos[lvw_pkg::AXIS_Z];
            v.last = (k == len - 1);
            voxel_expect.push_back(v);
        end
        return len;
    endfunction

    function automatic walk_row_t random_request();
        walk_row_t r;
        logic [lvw_pkg::FIELD_W-1:0] s [lvw_pkg::AXES];
        logic [lvw_pkg::OFF_W-1:0]   o [lvw_pkg::AXES];
        int shape, lone;
        shape = $urandom_range(0, 19);
        lone  = $urandom_range(0, 2);
        for (int i = 0; i < lvw_pkg::AXES; i++) begin
            case ($urandom_range(0, 5))
                0: s[i] = 16'h7fe0 + 16'($urandom_range(0, 31));
                1: s[i] = 16'h8000 + 16'($urandom_range(0, 31));
                2: s[i] = 16'($urandom_range(0, 63)) - 16'd32;
                default: s[i] = 16'($urandom);
            endcase
            if (shape == 0)
                o[i] = '0;
            else if (shape <= 6)
                o[i] = 7'($urandom_range(0, 14) - 7);
            else if (shape == 7)
                o[i] = (i == lone) ? 7'($urandom) : 7'd0;
            else
                o[i] = 7'($urandom);
        end
        r = '0;
        r.sx = s[lvw_pkg::AXIS_X]; r.sy = s[lvw_pkg::AXIS_Y]; r.sz = s[lvw_pkg::AXIS_Z];
        r.ox = o[lvw_pkg::AXIS_X]; r.oy = o[lvw_pkg::AXIS_Y]; r.oz = o[lvw_pkg::AXIS_Z];
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Offer one request in bursts with random gaps; return at the accepting edge.
    task automatic offer_request(input logic [lvw_pkg::S_DATA_W-1:0] req);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do @(posedge aclk); while (!s_axis_tready);
        requests_sent++;
    endtask

    // Hold the sender until every queued voxel has arrived.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (voxel_expect.size() != 0);
    endtask

    // Check results and drive the receiver's stall pattern.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_voxel.x = m_axis_tdata[lvw_pkg::FIELD_W-1:0];
            got_voxel.y = m_axis_tdata[2*lvw_pkg::FIELD_W-1:lvw_pkg::FIELD_W];
            got_voxel.z = m_axis_tdata[3*lvw_pkg::FIELD_W-1:2*lvw_pkg::FIELD_W];
            got_voxel.last = m_axis_tlast;
            if (voxel_expect.size() == 0) begin
                note_failure($sformatf("voxel (%h,%h,%h) last=%b with no request pending",
                                       got_voxel.x, got_voxel.y, got_voxel.z, got_voxel.last));
            end else begin
                want_voxel = voxel_expect.pop_front();
                voxels_checked++;
                if (got_voxel.x !== want_voxel.x || got_voxel.y !== want_voxel.y ||
                    got_voxel.z !== want_voxel.z || got_voxel.last !== want_voxel.last)
                    note_failure($sformatf("expected (%h,%h,%h) last=%b, got (%h,%h,%h) last=%b",
                                           want_voxel.x, want_voxel.y, want_voxel.z,
                                           want_voxel.last, got_voxel.x, got_voxel.y,
                                           got_voxel.z, got_voxel.last));
            end
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (ready_mode)
            0: ready_next = 1'b1;
            1: ready_next = $urandom_range(0, 1);
            default: begin
                if (hold_left > 0) begin
                    ready_next = 1'b0;
                    hold_left--;
                end else begin
                    ready_next = 1'b1;
                    if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(4, 16);
                end
            end
        endcase
        m_axis_tready <= ready_next;
    end

    initial begin
        int len;
        int walks_done;
        walk_row_t r;
        voxel_t typed_voxel;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            r = walk_rows[i];
            offer_request(pack_request(r));
            if (r.typed) begin
                if (r.one_voxel) begin
                    typed_voxel.x    = r.ex;
                    typed_voxel.y    = r.ey;
                    typed_voxel.z    = r.ez;
                    typed_voxel.last = 1'b1;
                    voxel_expect.push_back(typed_voxel);
                end
            end else begin
                len = plan_walk(pack_request(r));
                if (len > longest_walk) longest_walk = len;
            end
        end
        hold_until_drained();

        walks_done = 0;
        while (walks_done < RANDOM_WALKS) begin
            r = random_request();
            offer_request(pack_request(r));
            len = plan_walk(pack_request(r));
            if (len > longest_walk) longest_walk = len;
            if (len > 0) walks_done++;
            if (walks_done == RANDOM_WALKS / 2 && len > 0) hold_until_drained();
        end
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (voxel_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d directed), %0d voxels checked, longest walk %0d",
                 requests_sent, NUM_ROWS, voxels_checked, longest_walk);
        $display("failures: %0d, voxels still pending: %0d", failures, voxel_expect.size());
        if (failures == 0 && voxel_expect.size() == 0) begin
            $display("line_voxel_walk_3d_test: PASS");
        end else begin
            $display("line_voxel_walk_3d_test: FAIL");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("timeout with %0d voxels pending", voxel_expect.size());
        $display("line_voxel_walk_3d_test: FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/lvw_pkg.sv
src/lvw_setup.sv
src/lvw_step.sv
src/line_voxel_walk_3d.sv
verif/line_voxel_walk_3d_test.sv
